@@ rtl/dmp_pkg.sv @@
// Shared types, constants and helper functions for the distance message parser.
// No dependencies; every other file imports this package.
package dmp_pkg;

	localparam int PREFIX_LEN = 13;
	localparam int TEXT_LEN   = 13;
	localparam int TEXT_IDX_W = $clog2(TEXT_LEN);

	localparam int BYTE_W  = 8;
	localparam int DIST_W  = 16;
	localparam int KIND_W  = 2;
	localparam int MIN_W   = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [BYTE_W-1:0] POS_MAX = '1;

	localparam logic [KIND_W-1:0] KIND_DIST_ONE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DIST_TWO = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CMD_ERR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIGITS = 2'd1;

	localparam logic [BYTE_W-1:0] TERM_RESET = 8'h2E;
	localparam logic [MIN_W-1:0]  MIN_RESET  = 4'd3;

	localparam logic [BYTE_W-1:0] TEXT_ONE [TEXT_LEN] = '{
		8'h44, 8'h69, 8'h73, 8'h74, 8'h61, 8'h6E, 8'h63, 8'h65,
		8'h20, 8'h31, 8'h20, 8'h3D, 8'h20
	};
	localparam logic [BYTE_W-1:0] TEXT_TWO [TEXT_LEN] = '{
		8'h44, 8'h69, 8'h73, 8'h74, 8'h61, 8'h6E, 8'h63, 8'h65,
		8'h20, 8'h32, 8'h20, 8'h3D, 8'h20
	};

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DIST_W-1:0] dist_one;
		logic [DIST_W-1:0] dist_two;
		logic [BYTE_W-1:0] length;
		logic              err_pending;
	} result_t;

	// ASCII to digit mapping; letters map above nine and nothing is rejected.
	function automatic logic [BYTE_W-1:0] digit_of(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] d;
		if (b <= 8'h39 || b >= 8'h80) begin
			d = b - 8'h30;
		end else if (b >= 8'h41) begin
			d = b - 8'h37;
		end else begin
			d = b;
		end
		return d;
	endfunction

endpackage

@@ rtl/dmp_parser.sv @@
// Message framing state: prefix match, decimal accumulation and held distances.
// Depends on dmp_pkg; produces one result request per terminator byte.
module dmp_parser import dmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [BYTE_W-1:0] terminator,
	input  logic [MIN_W-1:0]  min_digits,
	output logic              res_push,
	output result_t           res_data
);

	logic [BYTE_W-1:0] pos_q;
	logic              pre_one_q;
	logic              pre_two_q;
	logic [DIST_W-1:0] acc_q;
	logic [DIST_W-1:0] dist_one_q;
	logic [DIST_W-1:0] dist_two_q;
	logic              err_q;

	logic                  is_term;
	logic                  in_prefix;
	logic                  in_text;
	logic [TEXT_IDX_W-1:0] text_idx;
	logic [DIST_W-1:0]     acc_next;
	logic                  long_enough;
	logic                  take_one;
	logic                  take_two;

	assign is_term   = (rx_byte == terminator);
	assign in_prefix = (pos_q < BYTE_W'(PREFIX_LEN));
	assign in_text   = (pos_q < BYTE_W'(TEXT_LEN));
	assign text_idx  = pos_q[TEXT_IDX_W-1:0];

	// value * 10 as two shifts and an add, wrapping at the accumulator width.
	assign acc_next = (acc_q << 3) + (acc_q << 1) + {{(DIST_W-BYTE_W){1'b0}}, digit_of(rx_byte)};

	assign long_enough = {1'b0, pos_q} >= ((BYTE_W+1)'(PREFIX_LEN) + (BYTE_W+1)'(min_digits));
	assign take_one    = long_enough && pre_one_q;
	assign take_two    = long_enough && !pre_one_q && pre_two_q;

	assign res_push = accept && is_term;

	always_comb begin
		res_data.dist_one    = take_one ? acc_q : dist_one_q;
		res_data.dist_two    = take_two ? acc_q : dist_two_q;
		res_data.length      = pos_q;
		res_data.err_pending = err_q;
		if (take_one) begin
			res_data.kind = KIND_DIST_ONE;
		end else if (take_two) begin
			res_data.kind = KIND_DIST_TWO;
		end else begin
			res_data.kind = KIND_CMD_ERR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			pre_one_q  <= 1'b1;
			pre_two_q  <= 1'b1;
			acc_q      <= '0;
			dist_one_q <= '0;
			dist_two_q <= '0;
			err_q      <= 1'b0;
		end else if (accept) begin
			if (is_term) begin
				pos_q     <= '0;
				pre_one_q <= 1'b1;
				pre_two_q <= 1'b1;
				acc_q     <= '0;
				if (take_one) begin
					dist_one_q <= acc_q;
				end
				if (take_two) begin
					dist_two_q <= acc_q;
				end
				err_q <= !(take_one || take_two);
			end else begin
				if (in_prefix) begin
					if (in_text) begin
						if (rx_byte != TEXT_ONE[text_idx]) begin
							pre_one_q <= 1'b0;
						end
						if (rx_byte != TEXT_TWO[text_idx]) begin
							pre_two_q <= 1'b0;
						end
					end
				end else begin
					acc_q <= acc_next;
				end
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/dmp_out_buf.sv @@
// Two-entry result buffer: an output register with a skid slot behind it.
// Depends on dmp_pkg for the result type.
module dmp_out_buf import dmp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;

	// The skid slot is only filled when the output is full, so one free slot
	// is enough to take any further request.
	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

@@ rtl/distance_message_parser.sv @@
// Distance message parser top level: configuration registers, parser, result buffer.
// Depends on dmp_pkg, dmp_parser and dmp_out_buf.
//
// The block takes one received byte per clock cycle and frames messages that
// end in the terminator byte (register 0, reset '.'). The first 13 bytes are
// matched against "Distance 1 = " and "Distance 2 = ", and later bytes build a
// decimal value that wraps at 16 bits. A terminator yields one result, held in
// the output register, or in its skid slot while the output register still
// holds a result that is not taken; other bytes yield none. Input ready drops
// only while both the output register and its skid slot hold results that
// have not been taken. Register 1 sets the fewest value bytes a command needs
// (reset 3); writes to other indexes are ignored.
module distance_message_parser import dmp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BYTE_W-1:0]     rx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [KIND_W-1:0]     msg_kind,
	output logic [DIST_W-1:0]     distance_one,
	output logic [DIST_W-1:0]     distance_two,
	output logic [BYTE_W-1:0]     msg_length,
	output logic                  error_pending,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [BYTE_W-1:0] term_q;
	logic [MIN_W-1:0]  min_q;
	logic              accept;
	logic              res_push;
	logic              space;
	result_t           res_data;
	result_t           out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= TERM_RESET;
			min_q  <= MIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TERMINATOR: term_q <= cfg_data[BYTE_W-1:0];
				CFG_MIN_DIGITS: min_q  <= cfg_data[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = space;
	assign accept   = in_valid && space;

	dmp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.terminator (term_q),
		.min_digits (min_q),
		.res_push   (res_push),
		.res_data   (res_data)
	);

	dmp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign msg_kind      = out_data.kind;
	assign distance_one  = out_data.dist_one;
	assign distance_two  = out_data.dist_two;
	assign msg_length    = out_data.length;
	assign error_pending = out_data.err_pending;

endmodule

@@ dv/tb_distance_message_parser.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for distance_message_parser: a directed table of messages and
// random byte streams under several register settings, checked against a local predictor.
// Depends on dmp_pkg and the parser RTL; needs no files or arguments.
module tb_distance_message_parser;
	import dmp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BYTES_PER_SEG = 115;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [BYTE_W-1:0]     rx_byte = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [KIND_W-1:0]     msg_kind;
	logic [DIST_W-1:0]     distance_one;
	logic [DIST_W-1:0]     distance_two;
	logic [BYTE_W-1:0]     msg_length;
	logic                  error_pending;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	distance_message_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.msg_kind(msg_kind),
		.distance_one(distance_one),
		.distance_two(distance_two),
		.msg_length(msg_length),
		.error_pending(error_pending),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state, mirroring the parser and its two registers.
	string             text_one = "Distance 1 = ";
	string             text_two = "Distance 2 = ";
	logic [BYTE_W-1:0] term_byte = TERM_RESET;
	logic [MIN_W-1:0]  min_digits = MIN_RESET;
	logic [BYTE_W-1:0] pos_count = '0;
	logic              match_one = 1'b1;
	logic              match_two = 1'b1;
	logic [DIST_W-1:0] accum = '0;
	logic [DIST_W-1:0] held_one = '0;
	logic [DIST_W-1:0] held_two = '0;
	logic              last_was_error = 1'b0;

	result_t expected_results [$];
	result_t oldest;
	int      error_count = 0;
	int      cycle_count = 0;
	int      send_idle_pct = 30;
	int      recv_idle_pct = 52;

	logic [BYTE_W-1:0] term_set [6] = '{8'h00, 8'hFF, 8'h0D, 8'h3B, 8'h0A, 8'h2E};
	logic [MIN_W-1:0]  min_set [6]  = '{4'd0, 4'd15, 4'd1, 4'd7, 4'd2, 4'd3};
	int                send_idle [3] = '{30, 52, 0};
	int                recv_idle [3] = '{52, 30, 0};

	typedef struct {
		string             head;
		logic [BYTE_W-1:0] fill;
		int                fill_count;
		bit                typed;
		result_t           answer;
	} directed_row_t;

	// Each row is sent as head, then fill_count copies of fill, then the terminator.
	directed_row_t directed_rows [14] = '{
		'{"", 8'h00, 0, 1'b1, '{KIND_CMD_ERR, 16'd0, 16'd0, 8'd0, 1'b0}},
		'{"Distance 1 = 123", 8'h00, 0, 1'b1, '{KIND_DIST_ONE, 16'd123, 16'd0, 8'd16, 1'b1}},
		'{"Distance 2 = 456", 8'h00, 0, 1'b1, '{KIND_DIST_TWO, 16'd123, 16'd456, 8'd16, 1'b0}},
		'{"Distance 1 = 12", 8'h00, 0, 1'b1, '{KIND_CMD_ERR, 16'd123, 16'd456, 8'd15, 1'b0}},
		'{"Distance 2 = 65535", 8'h00, 0, 1'b1,
			'{KIND_DIST_TWO, 16'd123, 16'd65535, 8'd18, 1'b1}},
		'{"Distance 2 = 65536", 8'h00, 0, 1'b1, '{KIND_DIST_TWO, 16'd123, 16'd0, 8'd18, 1'b0}},
		'{"Distance 3 = 100", 8'h00, 0, 1'b1, '{KIND_CMD_ERR, 16'd123, 16'd0, 8'd16, 1'b0}},
		'{"Distance 1 = AZ:@", 8'h00, 0, 1'b0, '0},
		'{"Distance 1 = 5", 8'hFF, 3, 1'b0, '0},
		'{"Distance 2 = ", 8'h00, 3, 1'b0, '0},
		'{"Distance 2 = ", 8'h39, 300, 1'b0, '0},
		'{"distance 1 = 999", 8'h00, 0, 1'b0, '0},
		'{"Distance 1 =x007", 8'h00, 0, 1'b0, '0},
		'{"Distance 1 = ", 8'h30, 3, 1'b0, '0}
	};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [BYTE_W-1:0] ascii_digit(input logic [BYTE_W-1:0] b);
		if (b >= 8'h3A && b <= 8'h40)
			return b;
		if (b >= 8'h41 && b <= 8'h7F)
			return b - 8'h37;
		return b - 8'h30;
	endfunction

	// Advances the predictor by one accepted byte; a terminator queues one result.
	task automatic parse_byte(input logic [BYTE_W-1:0] b);
		result_t r;
		logic    long_enough;
		if (b != term_byte) begin
			if (pos_count < PREFIX_LEN) begin
				if (pos_count < text_one.len()) begin
					if (b != text_one[pos_count])
						match_one = 1'b0;
					if (b != text_two[pos_count])
						match_two = 1'b0;
				end
			end else begin
				accum = accum * 16'd10 + {8'h00, ascii_digit(b)};
			end
			if (pos_count != POS_MAX)
				pos_count++;
		end else begin
			long_enough = (pos_count >= PREFIX_LEN + min_digits);
			r.err_pending = last_was_error;
			if (long_enough && match_one) begin
				held_one = accum;
				r.kind = KIND_DIST_ONE;
				last_was_error = 1'b0;
			end else if (long_enough && match_two) begin
				held_two = accum;
				r.kind = KIND_DIST_TWO;
				last_was_error = 1'b0;
			end else begin
				r.kind = KIND_CMD_ERR;
				last_was_error = 1'b1;
			end
			r.dist_one = held_one;
			r.dist_two = held_two;
			r.length = pos_count;
			expected_results.push_back(r);
			pos_count = '0;
			match_one = 1'b1;
			match_two = 1'b1;
			accum = '0;
		end
	endtask

	// Offers one byte and returns at the edge where it is taken.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		parse_byte(b);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == CFG_TERMINATOR)
			term_byte = data;
		else if (idx == CFG_MIN_DIGITS)
			min_digits = data[MIN_W-1:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Drops the request line and waits until every queued result has been taken.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_traffic(input int budget);
		logic [BYTE_W-1:0] msg [$];
		logic [BYTE_W-1:0] d;
		int                sent;
		int                pick;
		int                count;
		int                k;
		bit                sel;
		sent = 0;
		while (sent < budget) begin
			msg.delete();
			pick = $urandom_range(0, 99);
			sel = 1'($urandom_range(0, 1));
			if (pick < 80) begin
				for (k = 0; k < text_one.len(); k++)
					msg.push_back(sel ? text_two[k] : text_one[k]);
				if ($urandom_range(0, 7) == 0) begin
					k = $urandom_range(0, text_one.len() - 1);
					msg[k] = msg[k] ^ (8'h01 << $urandom_range(0, 7));
				end
				count = $urandom_range(0, min_digits + 3);
				// Now and then a message long enough to saturate the length count.
				if ($urandom_range(0, 49) == 0)
					count = $urandom_range(245, 300);
				repeat (count) begin
					if ($urandom_range(0, 9) != 0)
						d = 8'($urandom_range(8'h30, 8'h39));
					else
						d = 8'($urandom_range(0, 255));
					if (d == term_byte)
						d = 8'h37;
					msg.push_back(d);
				end
			end else if (pick < 92) begin
				count = $urandom_range(0, 20);
				repeat (count) msg.push_back(8'($urandom_range(0, 255)));
			end else begin
				count = $urandom_range(0, text_one.len() - 1);
				for (k = 0; k < count; k++)
					msg.push_back(sel ? text_two[k] : text_one[k]);
			end
			msg.push_back(term_byte);
			foreach (msg[j])
				send_byte(msg[j]);
			sent += msg.size();
		end
	endtask

	task automatic report_mismatch(input string note);
		$display("%0t: %s", $time, note);
		error_count++;
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result with no request pending, kind %0d", msg_kind));
			end else begin
				oldest = expected_results.pop_front();
				if (msg_kind !== oldest.kind)
					report_mismatch($sformatf("msg_kind %0d, expected %0d",
						msg_kind, oldest.kind));
				if (distance_one !== oldest.dist_one)
					report_mismatch($sformatf("distance_one %0d, expected %0d",
						distance_one, oldest.dist_one));
				if (distance_two !== oldest.dist_two)
					report_mismatch($sformatf("distance_two %0d, expected %0d",
						distance_two, oldest.dist_two));
				if (msg_length !== oldest.length)
					report_mismatch($sformatf("msg_length %0d, expected %0d",
						msg_length, oldest.length));
				if (error_pending !== oldest.err_pending)
					report_mismatch($sformatf("error_pending %0b, expected %0b",
						error_pending, oldest.err_pending));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int seg;
		int k;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			for (k = 0; k < directed_rows[i].head.len(); k++)
				send_byte(directed_rows[i].head[k]);
			repeat (directed_rows[i].fill_count) send_byte(directed_rows[i].fill);
			send_byte(term_byte);
			// The terminator was just taken, so its result is the newest one queued.
			if (directed_rows[i].typed)
				expected_results[expected_results.size() - 1] = directed_rows[i].answer;
		end
		for (seg = 0; seg < 6; seg++) begin
			send_idle_pct = send_idle[seg / 2];
			recv_idle_pct = recv_idle[seg / 2];
			settle();
			write_reg(CFG_SPARE_LO, 8'($urandom_range(0, 255)));
			write_reg(CFG_TERMINATOR, term_set[seg]);
			write_reg(CFG_MIN_DIGITS, {4'($urandom_range(0, 15)), min_set[seg]});
			write_reg(CFG_SPARE_HI, 8'($urandom_range(0, 255)));
			random_traffic(RANDOM_BYTES_PER_SEG);
		end
		settle();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
